// ===== hw/rtl/vcbs_pkg.sv =====
// Shared types, constants and the elapsed-time helper for the button sequencer.
package vcbs_pkg;

    localparam int unsigned DirW   = 5;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned LimitW = 16;
    localparam int unsigned CfgIdxW = 3;

    // Sequencer state codes.
    localparam logic [2:0] SEQ_IDLE  = 3'd0;
    localparam logic [2:0] SEQ_COIN  = 3'd1;
    localparam logic [2:0] SEQ_GAP   = 3'd2;
    localparam logic [2:0] SEQ_START = 3'd3;
    localparam logic [2:0] SEQ_WAIT  = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_HAS_COIN    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MENU_EN     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_COIN_PULSE  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_COIN_GAP    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_START_PULSE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RESET_HOLD  = 3'd5;

    // Reset values of the timing registers.
    localparam logic [LimitW-1:0] COIN_PULSE_RST  = 16'd100;
    localparam logic [LimitW-1:0] COIN_GAP_RST    = 16'd500;
    localparam logic [LimitW-1:0] START_PULSE_RST = 16'd100;
    localparam logic [LimitW-1:0] RESET_HOLD_RST  = 16'd3000;

    typedef struct packed {
        logic              has_coin_button;
        logic              menu_enabled;
        logic [LimitW-1:0] coin_pulse_ms;
        logic [LimitW-1:0] coin_gap_ms;
        logic [LimitW-1:0] start_pulse_ms;
        logic [LimitW-1:0] reset_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [DirW-1:0]  dir_fire_pressed;
        logic             start_pressed;
        logic             coin_pressed;
        logic [TimeW-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [DirW-1:0] dir_fire_out;
        logic            extra_out;
        logic            coin_out;
        logic            start_out;
        logic            volume_valid;
        logic            volume_up;
        logic            volume_down;
        logic            attract_reset;
        logic            do_reset;
    } t_result;

    // True when the wrapped time since stamp is strictly greater than limit.
    function automatic logic time_passed(input logic [TimeW-1:0]  now,
                                         input logic [TimeW-1:0]  stamp,
                                         input logic [LimitW-1:0] limit);
        logic [TimeW-1:0] elapsed;
        elapsed = now - stamp;
        return (elapsed[TimeW-1:LimitW] != '0) || (elapsed[LimitW-1:0] > limit);
    endfunction

endpackage

// ===== hw/rtl/vcbs_cfg.sv =====
// Configuration register file of the button sequencer.
module vcbs_cfg import vcbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [CfgIdxW-1:0] i_wr_index,
    input  logic [LimitW-1:0]  i_wr_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.has_coin_button <= 1'b0;
            r_cfg.menu_enabled    <= 1'b1;
            r_cfg.coin_pulse_ms   <= COIN_PULSE_RST;
            r_cfg.coin_gap_ms     <= COIN_GAP_RST;
            r_cfg.start_pulse_ms  <= START_PULSE_RST;
            r_cfg.reset_hold_ms   <= RESET_HOLD_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_HAS_COIN:    r_cfg.has_coin_button <= i_wr_data[0];
                REG_MENU_EN:     r_cfg.menu_enabled    <= i_wr_data[0];
                REG_COIN_PULSE:  r_cfg.coin_pulse_ms   <= i_wr_data;
                REG_COIN_GAP:    r_cfg.coin_gap_ms     <= i_wr_data;
                REG_START_PULSE: r_cfg.start_pulse_ms  <= i_wr_data;
                REG_RESET_HOLD:  r_cfg.reset_hold_ms   <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/vcbs_core.sv =====
// Per-poll core of the button sequencer: coin sequence, volume, attract edges, hold timer.
module vcbs_core import vcbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_result
);

    logic [2:0]       r_seq_state, n_seq_state;
    logic [TimeW-1:0] r_seq_start, n_seq_start;
    logic             r_hold_active, n_hold_active;
    logic [TimeW-1:0] r_hold_start, n_hold_start;
    logic [2:0]       r_last_bits;

    logic       up, down, extra, hold_eff;
    logic [2:0] cur_bits;

    assign up       = i_item.dir_fire_pressed[2];
    assign down     = i_item.dir_fire_pressed[3];
    assign extra    = i_cfg.has_coin_button ? i_item.coin_pressed : i_item.start_pressed;
    assign cur_bits = {down, up, extra};
    // Pressing up or down while extra is held restarts the hold timer.
    assign hold_eff = r_hold_active && !(extra && (up || down));

    always_comb begin
        n_seq_state = r_seq_state;
        n_seq_start = r_seq_start;
        if (i_cfg.has_coin_button) begin
            n_seq_state = SEQ_IDLE;
        end else begin
            unique case (r_seq_state)
                SEQ_COIN: begin
                    if (time_passed(i_item.now_ms, r_seq_start, i_cfg.coin_pulse_ms)) begin
                        n_seq_state = SEQ_GAP;
                        n_seq_start = i_item.now_ms;
                    end
                end
                SEQ_GAP: begin
                    if (time_passed(i_item.now_ms, r_seq_start, i_cfg.coin_gap_ms)) begin
                        n_seq_state = SEQ_START;
                        n_seq_start = i_item.now_ms;
                    end
                end
                SEQ_START: begin
                    if (time_passed(i_item.now_ms, r_seq_start, i_cfg.start_pulse_ms)) begin
                        n_seq_state = SEQ_WAIT;
                        n_seq_start = i_item.now_ms;
                    end
                end
                SEQ_WAIT: begin
                    if (!extra) n_seq_state = SEQ_IDLE;
                end
                default: begin
                    n_seq_state = SEQ_IDLE;
                    if (extra) begin
                        n_seq_state = SEQ_COIN;
                        n_seq_start = i_item.now_ms;
                    end
                end
            endcase
        end

        n_hold_active = i_cfg.menu_enabled && extra;
        n_hold_start  = r_hold_start;
        if (i_cfg.menu_enabled && extra && !hold_eff) n_hold_start = i_item.now_ms;
    end

    always_comb begin
        o_result.dir_fire_out = i_item.dir_fire_pressed;
        o_result.extra_out    = extra;
        if (i_cfg.has_coin_button) begin
            o_result.coin_out  = i_item.coin_pressed;
            o_result.start_out = i_item.start_pressed;
        end else begin
            o_result.coin_out  = (n_seq_state == SEQ_COIN);
            o_result.start_out = (n_seq_state == SEQ_START) || (n_seq_state == SEQ_WAIT);
        end
        o_result.volume_valid  = extra;
        o_result.volume_up     = extra && up;
        o_result.volume_down   = extra && down;
        o_result.attract_reset = i_cfg.menu_enabled && ((cur_bits & ~r_last_bits) != 3'b000);
        // A timer started on this poll has zero elapsed time, so only a running one counts.
        o_result.do_reset = i_cfg.menu_enabled && extra && hold_eff &&
                            time_passed(i_item.now_ms, r_hold_start, i_cfg.reset_hold_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_state   <= SEQ_IDLE;
            r_seq_start   <= '0;
            r_hold_active <= 1'b0;
            r_hold_start  <= '0;
            r_last_bits   <= 3'b000;
        end else if (i_fire) begin
            r_seq_state   <= n_seq_state;
            r_seq_start   <= n_seq_start;
            r_hold_active <= n_hold_active;
            r_hold_start  <= n_hold_start;
            r_last_bits   <= cur_bits;
        end
    end

endmodule

// ===== hw/rtl/virtual_coin_button_sequencer.sv =====
// Top level of the virtual coin button sequencer: input register, core and result register.
//
// Usage: each poll request on the input channel carries the pressed directions and
// fire, start, coin and a free-running millisecond timestamp. It produces exactly one
// result request with the arcade button word, volume requests, the attract-reset
// pulse and the hold-to-reset flag. Both channels use valid and stall: a request moves
// at a clock edge where valid is high and stall is low.
// Throughput is one poll per clock while the receiver does not stall. The poll lands in
// the input register, the core evaluates it in one pass (one 32-bit subtract and compare
// per timer) and its result lands in the result register, where it waits for the receiver.
// When the receiver stalls, the result register holds its request and the input
// register keeps one more poll; only when both are full does the input side stall.
// Sequencer and timer state advance only when a poll moves from the input register
// to the result register, so stalls never repeat or drop a poll.
// The configuration channel (valid and ready, index and data) is always ready and
// should be written only while no poll is in flight. A synchronous active-low reset
// empties both registers, restores the register defaults and puts the sequence idle.
module virtual_coin_button_sequencer import vcbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Poll channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DirW-1:0]    i_dir_fire_pressed,
    input  logic               i_start_pressed,
    input  logic               i_coin_pressed,
    input  logic [TimeW-1:0]   i_now_ms,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DirW-1:0]    o_dir_fire_out,
    output logic               o_extra_out,
    output logic               o_coin_out,
    output logic               o_start_out,
    output logic               o_volume_valid,
    output logic               o_volume_up,
    output logic               o_volume_down,
    output logic               o_attract_reset,
    output logic               o_do_reset,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [LimitW-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_item   r_item;
    t_result core_result, r_result;
    logic    r_in_valid, r_out_valid;
    logic    advance, in_accept;

    // The poll in the input register moves on when the result register is free
    // or is being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    vcbs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    vcbs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_result (core_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.dir_fire_pressed <= i_dir_fire_pressed;
            r_item.start_pressed    <= i_start_pressed;
            r_item.coin_pressed     <= i_coin_pressed;
            r_item.now_ms           <= i_now_ms;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_dir_fire_out  = r_result.dir_fire_out;
    assign o_extra_out     = r_result.extra_out;
    assign o_coin_out      = r_result.coin_out;
    assign o_start_out     = r_result.start_out;
    assign o_volume_valid  = r_result.volume_valid;
    assign o_volume_up     = r_result.volume_up;
    assign o_volume_down   = r_result.volume_down;
    assign o_attract_reset = r_result.attract_reset;
    assign o_do_reset      = r_result.do_reset;

    // A poll that cannot move on stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input register lost a waiting poll");

    // The virtual sequence never drives coin and start together.
    a_seq_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !cfg.has_coin_button) |-> !(o_coin_out && o_start_out))
        else $error("virtual coin and start asserted together");

    // Volume requests only come with extra held.
    a_vol_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_volume_valid) |-> (!o_volume_up && !o_volume_down))
        else $error("volume request without extra held");

    // Hold-to-reset needs a steady hold of extra with no up, down or fresh edge.
    a_hold_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_do_reset) |->
            (o_volume_valid && !o_volume_up && !o_volume_down && !o_attract_reset))
        else $error("do_reset without a steady hold of extra");

endmodule

// ===== tb/sv/virtual_coin_button_sequencer_tb.sv =====
// Self-checking testbench for the virtual coin button sequencer: directed and random polls.
module virtual_coin_button_sequencer_tb;
    import vcbs_pkg::*;

    // A run fails if this many cycles pass in a row with no request moving on any channel.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Cycles to let pass after the last result before the block counts as idle.
    localparam int unsigned PIPE_DRAIN = 4;
    // Percentage of cycles in which either side idles while idling is enabled.
    localparam int unsigned IDLE_PCT = 19;
    // Random traffic is split into phases, each with its own register setting.
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned POLLS_PER_PHASE = 125;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [DirW-1:0]    i_dir_fire_pressed = '0;
    logic               i_start_pressed = 1'b0;
    logic               i_coin_pressed = 1'b0;
    logic [TimeW-1:0]   i_now_ms = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [DirW-1:0]    o_dir_fire_out;
    logic               o_extra_out;
    logic               o_coin_out;
    logic               o_start_out;
    logic               o_volume_valid;
    logic               o_volume_up;
    logic               o_volume_down;
    logic               o_attract_reset;
    logic               o_do_reset;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [LimitW-1:0]  i_cfg_data = '0;

    virtual_coin_button_sequencer u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_dir_fire_pressed (i_dir_fire_pressed),
        .i_start_pressed    (i_start_pressed),
        .i_coin_pressed     (i_coin_pressed),
        .i_now_ms           (i_now_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_dir_fire_out     (o_dir_fire_out),
        .o_extra_out        (o_extra_out),
        .o_coin_out         (o_coin_out),
        .o_start_out        (o_start_out),
        .o_volume_valid     (o_volume_valid),
        .o_volume_up        (o_volume_up),
        .o_volume_down      (o_volume_down),
        .o_attract_reset    (o_attract_reset),
        .o_do_reset         (o_do_reset),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // The predictor's copy of the registers, starting from their reset values.
    t_cfg cfg_model = {1'b0, 1'b1, COIN_PULSE_RST, COIN_GAP_RST, START_PULSE_RST,
                       RESET_HOLD_RST};

    // The predictor's copy of the sequencer and timer state, all zero after reset.
    logic [2:0]       seq_phase = SEQ_IDLE;
    logic [TimeW-1:0] seq_stamp = '0;
    logic             hold_on = 1'b0;
    logic [TimeW-1:0] hold_stamp = '0;
    logic [2:0]       prev_edges = '0;   // {down, up, extra} seen on the previous poll

    // Button words predicted for accepted polls, oldest first.
    t_result expected_words[$];

    // When low, neither side idles or stalls; used for a stretch of full-rate traffic.
    logic idling_on = 1'b1;

    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    // Wrapping elapsed-time test: true only when the distance is strictly above the limit.
    function automatic logic elapsed_over(input logic [TimeW-1:0]  now,
                                          input logic [TimeW-1:0]  stamp,
                                          input logic [LimitW-1:0] limit);
        logic [TimeW-1:0] delta;
        delta = now - stamp;
        return delta > TimeW'(limit);
    endfunction

    // Advances the predictor by one poll and returns the button word it should produce.
    function automatic t_result predict_buttons(input t_item p);
        t_result    r;
        logic       up;
        logic       down;
        logic       extra;
        logic [2:0] cur_edges;
        up = p.dir_fire_pressed[2];
        down = p.dir_fire_pressed[3];
        // The extra button is the coin button when one is wired, otherwise start.
        extra = cfg_model.has_coin_button ? p.coin_pressed : p.start_pressed;
        cur_edges = {down, up, extra};
        r = '0;
        r.dir_fire_out = p.dir_fire_pressed;
        r.extra_out = extra;

        if (cfg_model.has_coin_button) begin
            // With a real coin button the virtual sequence is parked in idle.
            seq_phase = SEQ_IDLE;
            r.coin_out = p.coin_pressed;
            r.start_out = p.start_pressed;
        end else begin
            case (seq_phase)
                SEQ_COIN: begin
                    if (elapsed_over(p.now_ms, seq_stamp, cfg_model.coin_pulse_ms)) begin
                        seq_phase = SEQ_GAP;
                        seq_stamp = p.now_ms;
                    end
                end
                SEQ_GAP: begin
                    if (elapsed_over(p.now_ms, seq_stamp, cfg_model.coin_gap_ms)) begin
                        seq_phase = SEQ_START;
                        seq_stamp = p.now_ms;
                    end
                end
                SEQ_START: begin
                    if (elapsed_over(p.now_ms, seq_stamp, cfg_model.start_pulse_ms)) begin
                        seq_phase = SEQ_WAIT;
                        seq_stamp = p.now_ms;
                    end
                end
                SEQ_WAIT: begin
                    if (!extra) begin
                        seq_phase = SEQ_IDLE;
                    end
                end
                default: begin
                    seq_phase = SEQ_IDLE;
                    if (extra) begin
                        seq_phase = SEQ_COIN;
                        seq_stamp = p.now_ms;
                    end
                end
            endcase
            r.coin_out = (seq_phase == SEQ_COIN);
            r.start_out = (seq_phase == SEQ_START) || (seq_phase == SEQ_WAIT);
        end

        // Holding extra turns up and down into volume requests and restarts the hold timer.
        if (extra) begin
            r.volume_valid = 1'b1;
            r.volume_up = up;
            r.volume_down = down;
            if (up || down) begin
                hold_on = 1'b0;
            end
        end

        if (cfg_model.menu_enabled) begin
            r.attract_reset = |(cur_edges & ~prev_edges);
            if (extra) begin
                if (!hold_on) begin
                    hold_on = 1'b1;
                    hold_stamp = p.now_ms;
                end
                r.do_reset = elapsed_over(p.now_ms, hold_stamp, cfg_model.reset_hold_ms);
            end else begin
                hold_on = 1'b0;
            end
        end else begin
            hold_on = 1'b0;
        end
        prev_edges = cur_edges;
        return r;
    endfunction

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error(what, got, want);
        end
    endtask

    // Result side: every accepted result is held against the oldest prediction.
    // Outputs are sampled right after the edge, so they still show the values that the
    // edge itself saw; the stall for the next cycle is chosen afterwards.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_error("result with no poll pending", 32'(o_dir_fire_out), '0);
            end else begin
                want = expected_words.pop_front();
                check_field("dir_fire_out", 32'(o_dir_fire_out), 32'(want.dir_fire_out));
                check_field("extra_out", 32'(o_extra_out), 32'(want.extra_out));
                check_field("coin_out", 32'(o_coin_out), 32'(want.coin_out));
                check_field("start_out", 32'(o_start_out), 32'(want.start_out));
                check_field("volume_valid", 32'(o_volume_valid), 32'(want.volume_valid));
                check_field("volume_up", 32'(o_volume_up), 32'(want.volume_up));
                check_field("volume_down", 32'(o_volume_down), 32'(want.volume_down));
                check_field("attract_reset", 32'(o_attract_reset), 32'(want.attract_reset));
                check_field("do_reset", 32'(o_do_reset), 32'(want.do_reset));
            end
        end
        i_out_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: any request moving on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("virtual_coin_button_sequencer verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one poll and returns in the time step of the edge that accepts it. Valid is
    // left high on return, so back-to-back polls keep it high without a dip; random idle
    // cycles come before the poll is offered and never depend on the stall.
    task automatic send_poll(input t_item p);
        while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_dir_fire_pressed <= p.dir_fire_pressed;
        i_start_pressed <= p.start_pressed;
        i_coin_pressed <= p.coin_pressed;
        i_now_ms <= p.now_ms;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_words.push_back(predict_buttons(p));
    endtask

    task automatic press_buttons(input logic [DirW-1:0] dir, input logic start,
                                 input logic coin, input logic [TimeW-1:0] now);
        t_item p;
        p.dir_fire_pressed = dir;
        p.start_pressed = start;
        p.coin_pressed = coin;
        p.now_ms = now;
        send_poll(p);
    endtask

    // Stops offering polls and waits until every predicted word has come back, then
    // lets the pipeline drain further so that it is idle for register writes.
    task automatic settle_polls();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Holds a register write until the block takes it; valid stays high on return.
    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [LimitW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Writes all six registers. Only bit 0 of the two one-bit registers counts, so the pad
    // (inverted for the menu register) fills the unused data bits above it.
    task automatic program_regs(input t_cfg c, input logic [LimitW-2:0] pad);
        write_reg(REG_HAS_COIN, {pad, c.has_coin_button});
        write_reg(REG_MENU_EN, {~pad, c.menu_enabled});
        write_reg(REG_COIN_PULSE, c.coin_pulse_ms);
        write_reg(REG_COIN_GAP, c.coin_gap_ms);
        write_reg(REG_START_PULSE, c.start_pulse_ms);
        write_reg(REG_RESET_HOLD, c.reset_hold_ms);
        i_cfg_valid <= 1'b0;
        cfg_model = c;
    endtask

    // The full virtual coin sequence with the reset timings (100, 500, 100 and 3000 ms).
    // Each step fires one millisecond after its limit, never exactly at it, and holding
    // start for more than three seconds raises do_reset. Start stays held at the end so
    // that the next test finds the sequence waiting for release.
    task automatic test_default_sequence();
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd1000);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd1100);
        press_buttons(5'b00001, 1'b1, 1'b0, 32'd1101);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd1601);
        press_buttons(5'b10000, 1'b1, 1'b0, 32'd1602);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd1703);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd4000);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd4001);
        settle_polls();
    endtask

    // With a coin button wired, coin and start pass straight through and the held
    // sequence drops to idle. Up and down while extra is held restart the hold timer,
    // so with a zero hold limit do_reset waits for the next poll.
    task automatic test_pass_through();
        program_regs({1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0}, '0);
        press_buttons(5'b11111, 1'b1, 1'b1, 32'd0);
        press_buttons(5'b00000, 1'b0, 1'b1, 32'd5);
        press_buttons(5'b00100, 1'b1, 1'b0, 32'd6);
        press_buttons(5'b01000, 1'b0, 1'b0, 32'd7);
        settle_polls();
    endtask

    // Zero limits step the sequence on every poll whose time has moved at all. The menu
    // is off, so neither attract_reset nor do_reset may show despite edges and holds.
    task automatic test_zero_limits_menu_off();
        program_regs({1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}, '0);
        press_buttons(5'b01100, 1'b1, 1'b0, 32'd10);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd10);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd11);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd12);
        press_buttons(5'b00000, 1'b1, 1'b0, 32'd13);
        press_buttons(5'b00000, 1'b0, 1'b1, 32'd13);
        settle_polls();
    endtask

    // Largest limits across the 32-bit wrap of the timestamp. A jump back in time reads
    // as a huge elapsed time and fires the gap at once; releasing start during the
    // start pulse leaves start asserted until its time is up.
    task automatic test_limit_extremes();
        logic [TimeW-1:0] t0;
        t0 = 32'hFFFF_F000;
        program_regs({1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '0);
        press_buttons(5'b00000, 1'b1, 1'b0, t0);
        press_buttons(5'b00000, 1'b1, 1'b0, t0 + 32'd65535);
        press_buttons(5'b00000, 1'b1, 1'b0, t0 + 32'd65536);
        press_buttons(5'b00000, 1'b1, 1'b0, t0);
        press_buttons(5'b00000, 1'b0, 1'b0, t0 + 32'd1);
        settle_polls();
    endtask

    // Limits are mostly small so that whole sequences and holds play out between the
    // time steps of the random polls, with occasional zero, full-range and maximum ones.
    function automatic logic [LimitW-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return LimitW'($urandom_range(0, 65535));
            default: return LimitW'($urandom_range(0, 40));
        endcase
    endfunction

    // Random polls in phases, each under a fresh register setting. Buttons are held
    // across polls and toggle only now and then, so presses last long enough to walk
    // the sequence and the hold timer; a few polls are pure noise with a random
    // timestamp. One phase runs with no idling on either side. Each phase ends with the
    // sender waiting until every result has come back.
    task automatic test_random_traffic();
        t_cfg             c;
        t_item            p;
        logic [DirW-1:0]  held_dir;
        logic             held_start;
        logic             held_coin;
        logic [TimeW-1:0] clock_ms;
        int unsigned      step_max;
        held_dir = '0;
        held_start = 1'b0;
        held_coin = 1'b0;
        clock_ms = $urandom;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            c.has_coin_button = ($urandom_range(0, 3) == 0);
            c.menu_enabled = ($urandom_range(0, 3) != 0);
            c.coin_pulse_ms = pick_limit();
            c.coin_gap_ms = pick_limit();
            c.start_pulse_ms = pick_limit();
            c.reset_hold_ms = pick_limit();
            program_regs(c, (LimitW-1)'($urandom));
            idling_on = (phase != 3);
            step_max = $urandom_range(1, 20);
            for (int unsigned n = 0; n < POLLS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 6) begin
                    held_dir = DirW'($urandom);
                    held_start = 1'($urandom);
                    held_coin = 1'($urandom);
                    clock_ms = $urandom;
                end else begin
                    for (int b = 0; b < DirW; b++) begin
                        if ($urandom_range(0, 99) < 10) begin
                            held_dir[b] = ~held_dir[b];
                        end
                    end
                    if ($urandom_range(0, 99) < 15) begin
                        held_start = ~held_start;
                    end
                    if ($urandom_range(0, 99) < 15) begin
                        held_coin = ~held_coin;
                    end
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                end
                p.dir_fire_pressed = held_dir;
                p.start_pressed = held_start;
                p.coin_pressed = held_coin;
                p.now_ms = clock_ms;
                send_poll(p);
            end
            settle_polls();
            idling_on = 1'b1;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_sequence();
        test_pass_through();
        test_zero_limits_menu_off();
        test_limit_extremes();
        test_random_traffic();
        settle_polls();
        if (error_count == 0) begin
            $display("virtual_coin_button_sequencer verification clean");
        end else begin
            $display("virtual_coin_button_sequencer verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/vcbs_pkg.sv
hw/rtl/vcbs_cfg.sv
hw/rtl/vcbs_core.sv
hw/rtl/virtual_coin_button_sequencer.sv
tb/sv/virtual_coin_button_sequencer_tb.sv
